@@ src/oec_pkg.sv @@
// shared types, constants and constant functions of the elastic ease-out curve unit
`default_nettype none
package oec_pkg;

	// fractional bits of the unit position u
	localparam int STEP_BITS = 16;
	localparam int FIELD_W = 16;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register map: the index is paddr[2]
	localparam logic REG_TOTAL = 1'b0;
	localparam logic [FIELD_W-1:0] TOTAL_RESET = 16'd100;

	// 10*u plus the phase offset needs four more bits than u
	localparam int A_W = STEP_BITS + 4;
	localparam logic [A_W-1:0] PHASE_OFS = A_W'(64'd9 << (STEP_BITS - 2));
	localparam logic [A_W-1:0] TEN = A_W'(10);

	// divide by three through a reciprocal, exact for a below 2^(STEP_BITS+4)
	localparam int M3_SHIFT = STEP_BITS + 6;
	localparam int M3_W = STEP_BITS + 5;
	localparam logic [M3_W-1:0] M3 = M3_W'(((65'd1 << M3_SHIFT) + 65'd2) / 65'd3);
	localparam int P3_W = A_W + M3_W;
	localparam int Q3_W = P3_W - M3_SHIFT;
	localparam int FRAC_SH = 32 - STEP_BITS;
	localparam logic [31:0] THIRD1 = 32'((64'd1 << FRAC_SH) / 64'd3);
	localparam logic [31:0] THIRD2 = 32'((64'd2 << FRAC_SH) / 64'd3);

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [FIELD_W-1:0] ONE_Q14 = 16'd16384;
	localparam logic [63:0] ROUND_Q48 = 64'd1 << 47;

	// horner divisors of the sine series, innermost term first
	localparam int HORNER_STEPS = 5;
	localparam int DIV_SHIFT = 34;
	localparam int HD_W = 7;
	localparam logic [HORNER_STEPS-1:0][HD_W-1:0] HORNER_D =
		{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};
	localparam logic [HORNER_STEPS-1:0][31:0] HORNER_M = {
		32'((64'd1 << DIV_SHIFT) / 64'd6),
		32'((64'd1 << DIV_SHIFT) / 64'd20),
		32'((64'd1 << DIV_SHIFT) / 64'd42),
		32'((64'd1 << DIV_SHIFT) / 64'd72),
		32'((64'd1 << DIV_SHIFT) / 64'd110)};

	typedef logic [STEP_BITS-1:0][31:0] exp_fac_t;

	// floor square root, elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] vv;
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] t;
		vv = v;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			t = r + b;
			if (vv >= t) begin
				vv = vv - t;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// factors 2^(-2^-(j+1)) in Q0.32, each the root of the one before
	function automatic exp_fac_t exp_factors();
		exp_fac_t t;
		logic [63:0] c;
		c = 64'h8000_0000;
		for (int j = 0; j < STEP_BITS; j++) begin
			c = isqrt64(c << 32);
			t[j] = c[31:0];
		end
		return t;
	endfunction

	localparam exp_fac_t EXP_FACTOR = exp_factors();

	// one word in flight, carried down the whole pipeline
	typedef struct packed {
		logic zero;
		logic full;
		logic [FIELD_W-1:0] total;
		logic [FIELD_W-1:0] rem;
		logic [STEP_BITS-1:0] u;
		logic [STEP_BITS-1:0] f;
		logic [3:0] k;
		logic unity;
		logic [31:0] m;
		logic [A_W-1:0] a;
		logic [P3_W-1:0] p3;
		logic [31:0] g;
		logic [1:0] quad;
		logic [30:0] x;
		logic [31:0] x2;
		logic [30:0] h;
		logic [31:0] p;
		logic [63:0] d;
		logic [30:0] sn;
		logic [62:0] mp;
	} item_t;

endpackage
`default_nettype wire

@@ src/ease_out_elastic_curve_unit.sv @@
// top level of the elastic ease-out curve unit: register port and word pipeline
// throughput: one word per cycle while the output is not stalled; a chain of division, exp2 and horner cells
// with a valid bit per stage, so bubbles close up while the output is stalled
// depth is set by one quotient bit per division cell and one factor per exp2 cell
// reset clears every valid bit and loads total_steps with 100
`default_nettype none
module ease_out_elastic_curve_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [oec_pkg::FIELD_W-1:0]     step_index,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [oec_pkg::FIELD_W-1:0]          eased_value,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [oec_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [oec_pkg::DATA_W-1:0]      pwdata,
	output logic [oec_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready
);
	import oec_pkg::*;

	// ---------------- register port ----------------
	logic [FIELD_W-1:0] total_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOTAL) begin
			total_q <= pwdata[FIELD_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TOTAL) ? DATA_W'(total_q) : '0;

	// ---------------- stage valid, ready and word registers ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;
	item_t itm_s1, itm_s2, itm_s3, itm_s4, itm_s5, itm_s6, itm_s7, itm_s8;
	item_t nxt1, nxt2, nxt3, nxt4, nxt5, nxt6, nxt7, nxt8;
	logic [FIELD_W-1:0] eased_s9, res9;

	// cell chains: index 0 is the feed, the last index the drain
	logic div_vld [STEP_BITS+1];
	logic div_rdy [STEP_BITS+1];
	item_t div_itm [STEP_BITS+1];
	logic exp_vld [STEP_BITS+1];
	logic exp_rdy [STEP_BITS+1];
	item_t exp_itm [STEP_BITS+1];
	logic hor_vld [HORNER_STEPS+1];
	logic hor_rdy [HORNER_STEPS+1];
	item_t hor_itm [HORNER_STEPS+1];

	// ---------------- s1: saturate the step, flag the two ends ----------------
	logic [FIELD_W-1:0] tot1, s1;

	always_comb begin
		nxt1 = '0;
		// a total of zero counts as one
		tot1 = (total_q == '0) ? FIELD_W'(1) : total_q;
		s1 = (step_index > tot1) ? tot1 : step_index;
		nxt1.total = tot1;
		nxt1.rem = s1;
		nxt1.zero = (s1 == '0);
		nxt1.full = (s1 == tot1);
		nxt1.unity = 1'b1;
	end

	assign in_stall = !rdy_s1;
	assign rdy_s1 = !vld_s1 || div_rdy[0];

	assign div_vld[0] = vld_s1;
	assign div_itm[0] = itm_s1;

	// u = (s << STEP_BITS) / total, one bit per cell
	for (genvar i = 0; i < STEP_BITS; i++) begin : g_div
		oec_div_cell u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (div_vld[i]),
			.up_ready (div_rdy[i]),
			.up_item  (div_itm[i]),
			.dn_valid (div_vld[i+1]),
			.dn_ready (div_rdy[i+1]),
			.dn_item  (div_itm[i+1])
		);
	end

	assign div_rdy[STEP_BITS] = rdy_s2;

	// ---------------- s2: e = 10u split into integer and fraction ----------------
	logic [A_W-1:0] e2;

	always_comb begin
		nxt2 = div_itm[STEP_BITS];
		e2 = A_W'(div_itm[STEP_BITS].u) * TEN;
		nxt2.f = e2[STEP_BITS-1:0];
		nxt2.k = e2[A_W-1:STEP_BITS];
		nxt2.m = '0;
		nxt2.unity = 1'b1;
		nxt2.a = e2 + PHASE_OFS;
	end

	assign rdy_s2 = !vld_s2 || exp_rdy[0];
	assign exp_vld[0] = vld_s2;
	assign exp_itm[0] = itm_s2;

	// 2^-f as a product of root factors, most significant fraction bit first
	for (genvar j = 0; j < STEP_BITS; j++) begin : g_exp
		oec_exp_cell u_exp (
			.clk      (clk),
			.arst_n   (arst_n),
			.factor   (EXP_FACTOR[j]),
			.up_valid (exp_vld[j]),
			.up_ready (exp_rdy[j]),
			.up_item  (exp_itm[j]),
			.dn_valid (exp_vld[j+1]),
			.dn_ready (exp_rdy[j+1]),
			.dn_item  (exp_itm[j+1])
		);
	end

	assign exp_rdy[STEP_BITS] = rdy_s3;

	// ---------------- s3: integer shift of exp2, start of the divide by three ----------------
	logic [32:0] gsh3;

	always_comb begin
		nxt3 = exp_itm[STEP_BITS];
		gsh3 = {exp_itm[STEP_BITS].unity, exp_itm[STEP_BITS].m} >> exp_itm[STEP_BITS].k;
		nxt3.g = gsh3[31:0];
		nxt3.p3 = P3_W'(exp_itm[STEP_BITS].a) * P3_W'(M3);
	end

	// ---------------- s4: phase in turns, quadrant fold ----------------
	logic [Q3_W-1:0] q4;
	logic [A_W-1:0] r4w;
	logic [31:0] frac4;
	logic [63:0] ph4;

	always_comb begin
		nxt4 = itm_s3;
		q4 = itm_s3.p3[P3_W-1:M3_SHIFT];
		r4w = itm_s3.a - (A_W'(q4) + (A_W'(q4) << 1));
		case (r4w[1:0])
			2'd1: frac4 = THIRD1;
			2'd2: frac4 = THIRD2;
			default: frac4 = '0;
		endcase
		ph4 = (64'(q4) << FRAC_SH) + 64'(frac4);
		nxt4.quad = ph4[31:30];
		// odd quadrants run the quarter wave backwards
		nxt4.x = ph4[30] ? ONE_Q30 - 31'(ph4[29:0]) : 31'(ph4[29:0]);
	end

	// ---------------- s5: angle in Q1.30 ----------------
	logic [61:0] ang5;

	always_comb begin
		nxt5 = itm_s4;
		ang5 = 62'(itm_s4.x) * 62'(HALF_PI_Q30);
		nxt5.x = ang5[60:30];
	end

	// ---------------- s6: square of the angle, horner seed ----------------
	logic [61:0] sq6;

	always_comb begin
		nxt6 = itm_s5;
		sq6 = 62'(itm_s5.x) * 62'(itm_s5.x);
		nxt6.x2 = sq6[61:30];
		nxt6.h = ONE_Q30;
	end

	assign rdy_s6 = !vld_s6 || hor_rdy[0];
	assign hor_vld[0] = vld_s6;
	assign hor_itm[0] = itm_s6;

	for (genvar n = 0; n < HORNER_STEPS; n++) begin : g_hor
		oec_horner_cell u_hor (
			.clk      (clk),
			.arst_n   (arst_n),
			.div      (HORNER_D[n]),
			.recip    (HORNER_M[n]),
			.up_valid (hor_vld[n]),
			.up_ready (hor_rdy[n]),
			.up_item  (hor_itm[n]),
			.dn_valid (hor_vld[n+1]),
			.dn_ready (hor_rdy[n+1]),
			.dn_item  (hor_itm[n+1])
		);
	end

	assign hor_rdy[HORNER_STEPS] = rdy_s7;

	// ---------------- s7: sine magnitude ----------------
	logic [61:0] sp7;

	always_comb begin
		nxt7 = hor_itm[HORNER_STEPS];
		sp7 = 62'(hor_itm[HORNER_STEPS].x) * 62'(hor_itm[HORNER_STEPS].h);
		nxt7.sn = sp7[60:30];
	end

	// ---------------- s8: decay times sine ----------------
	always_comb begin
		nxt8 = itm_s7;
		nxt8.mp = 63'(itm_s7.g) * 63'(itm_s7.sn);
	end

	// ---------------- s9: round to Q2.14, sign, end cases ----------------
	logic [63:0] rnd9;
	logic [FIELD_W-1:0] mag9;

	always_comb begin
		rnd9 = 64'(itm_s8.mp) + ROUND_Q48;
		mag9 = rnd9[63:48];
		if (mag9 > ONE_Q14) mag9 = ONE_Q14;
		if (itm_s8.zero) begin
			res9 = '0;
		end else if (itm_s8.full) begin
			res9 = ONE_Q14;
		end else if (itm_s8.quad[1]) begin
			res9 = ONE_Q14 - mag9;
		end else begin
			res9 = ONE_Q14 + mag9;
		end
	end

	assign rdy_s9 = !vld_s9 || !out_stall;
	assign rdy_s8 = !vld_s8 || rdy_s9;
	assign rdy_s7 = !vld_s7 || rdy_s8;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= div_vld[STEP_BITS];
			if (rdy_s3) vld_s3 <= exp_vld[STEP_BITS];
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= hor_vld[HORNER_STEPS];
			if (rdy_s8) vld_s8 <= vld_s7;
			if (rdy_s9) vld_s9 <= vld_s8;
		end
	end

	// word registers load only on a transfer, so a stalled result holds
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) itm_s1 <= nxt1;
		if (rdy_s2 && div_vld[STEP_BITS]) itm_s2 <= nxt2;
		if (rdy_s3 && exp_vld[STEP_BITS]) itm_s3 <= nxt3;
		if (rdy_s4 && vld_s3) itm_s4 <= nxt4;
		if (rdy_s5 && vld_s4) itm_s5 <= nxt5;
		if (rdy_s6 && vld_s5) itm_s6 <= nxt6;
		if (rdy_s7 && hor_vld[HORNER_STEPS]) itm_s7 <= nxt7;
		if (rdy_s8 && vld_s7) itm_s8 <= nxt8;
		if (rdy_s9 && vld_s8) eased_s9 <= res9;
	end

	assign out_valid = vld_s9;
	assign eased_value = eased_s9;
endmodule
`default_nettype wire

@@ src/oec_div_cell.sv @@
// one restoring division cell: one quotient bit of step/total
`default_nettype none
module oec_div_cell (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         up_valid,
	output logic              up_ready,
	input  wire oec_pkg::item_t up_item,
	output logic              dn_valid,
	input  wire logic         dn_ready,
	output oec_pkg::item_t    dn_item
);
	import oec_pkg::*;

	logic vld_q;
	item_t itm_q;
	item_t nxt;
	logic [FIELD_W:0] sh;
	logic ge;

	always_comb begin
		nxt = up_item;
		sh = {up_item.rem, 1'b0};
		ge = sh >= {1'b0, up_item.total};
		nxt.rem = ge ? FIELD_W'(sh - {1'b0, up_item.total}) : sh[FIELD_W-1:0];
		nxt.u = {up_item.u[STEP_BITS-2:0], ge};
	end

	assign up_ready = !vld_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			itm_q <= nxt;
		end
	end

	assign dn_valid = vld_q;
	assign dn_item = itm_q;
endmodule
`default_nettype wire

@@ src/oec_exp_cell.sv @@
// one exp2 cell: multiplies in one root factor when its fraction bit is set
`default_nettype none
module oec_exp_cell (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [31:0]  factor,
	input  wire logic         up_valid,
	output logic              up_ready,
	input  wire oec_pkg::item_t up_item,
	output logic              dn_valid,
	input  wire logic         dn_ready,
	output oec_pkg::item_t    dn_item
);
	import oec_pkg::*;

	logic vld_q;
	item_t itm_q;
	item_t nxt;
	logic [63:0] prod;

	always_comb begin
		nxt = up_item;
		prod = 64'(up_item.m) * 64'(factor);
		nxt.f = {up_item.f[STEP_BITS-2:0], 1'b0};
		if (up_item.f[STEP_BITS-1]) begin
			// still at one: the product is the factor itself
			nxt.m = up_item.unity ? factor : prod[63:32];
			nxt.unity = 1'b0;
		end
	end

	assign up_ready = !vld_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			itm_q <= nxt;
		end
	end

	assign dn_valid = vld_q;
	assign dn_item = itm_q;
endmodule
`default_nettype wire

@@ src/oec_horner_cell.sv @@
// one horner step of the sine series: h = 1 - (x2*h)/div, three stages
`default_nettype none
module oec_horner_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [oec_pkg::HD_W-1:0]   div,
	input  wire logic [31:0]                recip,
	input  wire logic                       up_valid,
	output logic                            up_ready,
	input  wire oec_pkg::item_t             up_item,
	output logic                            dn_valid,
	input  wire logic                       dn_ready,
	output oec_pkg::item_t                  dn_item
);
	import oec_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	item_t itm_s1, itm_s2, itm_s3;
	item_t nxt1, nxt2, nxt3;
	logic [63:0] pr;
	logic [29:0] q0;
	logic [37:0] rem;
	logic [30:0] q;

	always_comb begin
		nxt1 = up_item;
		pr = 64'(up_item.x2) * 64'(up_item.h);
		nxt1.p = pr[61:30];
	end

	always_comb begin
		nxt2 = itm_s1;
		nxt2.d = 64'(itm_s1.p) * 64'(recip);
	end

	// reciprocal estimate is low by at most one
	always_comb begin
		nxt3 = itm_s2;
		q0 = itm_s2.d[63:DIV_SHIFT];
		rem = 38'(itm_s2.p) - 38'(q0) * 38'(div);
		q = 31'(q0) + 31'(rem >= 38'(div));
		nxt3.h = ONE_Q30 - q;
	end

	assign rdy_s3 = !vld_s3 || dn_ready;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= up_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) itm_s1 <= nxt1;
		if (rdy_s2 && vld_s1) itm_s2 <= nxt2;
		if (rdy_s3 && vld_s2) itm_s3 <= nxt3;
	end

	assign dn_valid = vld_s3;
	assign dn_item = itm_s3;
endmodule
`default_nettype wire

@@ src/oec_checker.sv @@
// port checker of the elastic ease-out curve unit and its bind
`default_nettype none
module oec_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic [oec_pkg::FIELD_W-1:0]     step_index,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [oec_pkg::FIELD_W-1:0]     eased_value,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [oec_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [oec_pkg::DATA_W-1:0]      pwdata,
	input  wire logic [oec_pkg::DATA_W-1:0]      prdata,
	input  wire logic                            pready
);
	import oec_pkg::*;

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(eased_value))
		else $error("result word changed while stalled");

	// the curve never leaves 0 .. 2.0
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> eased_value <= (ONE_Q14 << 1))
		else $error("curve value out of range");

	// a written total reads back
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_TOTAL
		|=> (paddr[2] != REG_TOTAL) || (prdata[FIELD_W-1:0] == $past(pwdata[FIELD_W-1:0])))
		else $error("total_steps readback mismatch");
endmodule

bind ease_out_elastic_curve_unit oec_checker u_oec_checker (.*);
`default_nettype wire
